[design/assert_macros.svh]
// Assertion helpers used by the checker file cpcm_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define CPCM_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("cpcm check failed");

// Next-cycle implication, disabled while reset is held.
`define CPCM_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("cpcm check failed");

// Next-cycle implication that also holds across reset.
`define CPCM_ASSERT_NXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("cpcm check failed");

`endif

[design/cpcm_pkg.sv]
package cpcm_pkg;

    localparam int COORD_WIDTH      = 24;
    localparam int NORMAL_FRAC_BITS = 14;
    localparam int RADIUS_WIDTH     = 22;

    // internal widths
    localparam int CENTER_W = COORD_WIDTH + 2;
    localparam int T_W      = COORD_WIDTH + 3;
    localparam int PROD_W   = 2 * T_W;
    localparam int DSQ_W    = PROD_W + 1;
    localparam int SUM_W    = RADIUS_WIDTH + 1;
    localparam int SQ_IN_W  = 2 * SUM_W;
    localparam int ROOT_W   = SUM_W;
    localparam int REM_W    = ROOT_W + 3;
    localparam int Q_W      = NORMAL_FRAC_BITS + 2;
    localparam int NUM_W    = SUM_W + NORMAL_FRAC_BITS + 1;
    localparam int R0_W     = NUM_W - Q_W;

    // result field widths
    localparam int PEN_W  = 23;
    localparam int NORM_W = 16;

    // input packing, lowest bit first
    localparam int P_AX  = 0;
    localparam int P_AY  = P_AX + COORD_WIDTH;
    localparam int P_OAX = P_AY + COORD_WIDTH;
    localparam int P_OAY = P_OAX + COORD_WIDTH;
    localparam int P_RA  = P_OAY + COORD_WIDTH;
    localparam int P_BX  = P_RA + RADIUS_WIDTH;
    localparam int P_BY  = P_BX + COORD_WIDTH;
    localparam int P_OBX = P_BY + COORD_WIDTH;
    localparam int P_OBY = P_OBX + COORD_WIDTH;
    localparam int P_RB  = P_OBY + COORD_WIDTH;
    localparam int IN_BITS = P_RB + RADIUS_WIDTH;
    localparam int IN_W  = ((IN_BITS + 7) / 8) * 8;

    // output packing, lowest bit first
    localparam int P_PEN = 0;
    localparam int P_NX  = P_PEN + PEN_W;
    localparam int P_NY  = P_NX + NORM_W;
    localparam int OUT_BITS = P_NY + NORM_W;
    localparam int OUT_W = ((OUT_BITS + 7) / 8) * 8;

    typedef struct packed {
        logic                    hit;
        logic                    zero;
        logic                    sx;
        logic                    sy;
        logic [SUM_W-1:0]        ax;
        logic [SUM_W-1:0]        ay;
        logic [SUM_W-1:0]        s;
        logic [RADIUS_WIDTH-1:0] minr;
        logic [SQ_IN_W-1:0]      dsq;
    } front_t;

    typedef struct packed {
        logic                    hit;
        logic                    zero;
        logic                    sx;
        logic                    sy;
        logic [SUM_W-1:0]        ax;
        logic [SUM_W-1:0]        ay;
        logic [SUM_W-1:0]        s;
        logic [RADIUS_WIDTH-1:0] minr;
    } side_t;

    typedef struct packed {
        logic             hit;
        logic             zero;
        logic             sx;
        logic             sy;
        logic [SUM_W-1:0] ax;
        logic [SUM_W-1:0] ay;
        logic [SUM_W-1:0] d;
        logic [PEN_W-1:0] pen;
    } dvin_t;

    typedef struct packed {
        logic             hit;
        logic             zero;
        logic             sx;
        logic             sy;
        logic [PEN_W-1:0] pen;
    } dvside_t;

    typedef struct packed {
        logic              hit;
        logic [PEN_W-1:0]  pen;
        logic [NORM_W-1:0] nx;
        logic [NORM_W-1:0] ny;
    } res_t;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } sq_t;

    typedef struct packed {
        logic [SUM_W-1:0] r;
        logic             q;
    } dv_t;

    // one digit of the bitwise square root
    function automatic sq_t sqrt_step(logic [REM_W-1:0] rem, logic [ROOT_W-1:0] root,
                                      logic [1:0] pair);
        logic [REM_W-1:0] cur;
        logic [REM_W-1:0] trial;
        sq_t              res;
        cur   = {rem[REM_W-3:0], pair};
        trial = REM_W'({root, 2'b01});
        if (cur >= trial) begin
            res.rem  = cur - trial;
            res.root = {root[ROOT_W-2:0], 1'b1};
        end else begin
            res.rem  = cur;
            res.root = {root[ROOT_W-2:0], 1'b0};
        end
        return res;
    endfunction

    // one quotient bit of restoring division
    function automatic dv_t div_step(logic [SUM_W-1:0] r, logic [SUM_W-1:0] d, logic nb);
        logic [SUM_W:0] cur;
        logic [SUM_W:0] diff;
        dv_t            res;
        cur  = {r, nb};
        diff = cur - {1'b0, d};
        if (cur >= {1'b0, d}) begin
            res.r = diff[SUM_W-1:0];
            res.q = 1'b1;
        end else begin
            res.r = cur[SUM_W-1:0];
            res.q = 1'b0;
        end
        return res;
    endfunction

endpackage

[design/cpcm_front.sv]
module cpcm_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic [cpcm_pkg::IN_W-1:0]    in_data,
    output logic                         out_valid,
    output cpcm_pkg::front_t             out_data
);
    import cpcm_pkg::*;

    logic [CENTER_W-1:0] cax_reg, cay_reg, cbx_reg, cby_reg;
    logic [CENTER_W-1:0] cax_next, cay_next, cbx_next, cby_next;
    logic [RADIUS_WIDTH-1:0] ra1_reg, rb1_reg;
    logic [T_W-1:0] tx_next, ty_next, mx_next, my_next;
    logic [T_W-1:0] mx_reg, my_reg;
    logic sx2_reg, sy2_reg, sx3_reg, sy3_reg;
    logic [SUM_W-1:0] s2_reg, s3_reg;
    logic [RADIUS_WIDTH-1:0] minr2_reg, minr3_reg;
    logic [PROD_W-1:0] sqx_reg, sqy_reg;
    logic [SQ_IN_W-1:0] ss_reg;
    logic [SUM_W-1:0] ax3_reg, ay3_reg;
    logic [DSQ_W-1:0] dsq_next;
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    front_t out_reg, out_next;

    // form centers: position plus offset plus radius on both axes
    function automatic logic [CENTER_W-1:0] center(logic [COORD_WIDTH-1:0] p,
                                                   logic [COORD_WIDTH-1:0] o,
                                                   logic [RADIUS_WIDTH-1:0] r);
        return {{2{p[COORD_WIDTH-1]}}, p} + {{2{o[COORD_WIDTH-1]}}, o} + CENTER_W'(r);
    endfunction

    assign cax_next = center(in_data[P_AX +: COORD_WIDTH], in_data[P_OAX +: COORD_WIDTH],
                             in_data[P_RA +: RADIUS_WIDTH]);
    assign cay_next = center(in_data[P_AY +: COORD_WIDTH], in_data[P_OAY +: COORD_WIDTH],
                             in_data[P_RA +: RADIUS_WIDTH]);
    assign cbx_next = center(in_data[P_BX +: COORD_WIDTH], in_data[P_OBX +: COORD_WIDTH],
                             in_data[P_RB +: RADIUS_WIDTH]);
    assign cby_next = center(in_data[P_BY +: COORD_WIDTH], in_data[P_OBY +: COORD_WIDTH],
                             in_data[P_RB +: RADIUS_WIDTH]);

    // translation and its magnitude
    assign tx_next = {cbx_reg[CENTER_W-1], cbx_reg} - {cax_reg[CENTER_W-1], cax_reg};
    assign ty_next = {cby_reg[CENTER_W-1], cby_reg} - {cay_reg[CENTER_W-1], cay_reg};
    assign mx_next = tx_next[T_W-1] ? (~tx_next + T_W'(1)) : tx_next;
    assign my_next = ty_next[T_W-1] ? (~ty_next + T_W'(1)) : ty_next;

    // squared distance against squared radius sum
    always_comb begin
        dsq_next       = DSQ_W'(sqx_reg) + DSQ_W'(sqy_reg);
        out_next.hit   = (dsq_next <= DSQ_W'(ss_reg));
        out_next.zero  = (dsq_next == '0);
        out_next.sx    = sx3_reg;
        out_next.sy    = sy3_reg;
        out_next.ax    = ax3_reg;
        out_next.ay    = ay3_reg;
        out_next.s     = s3_reg;
        out_next.minr  = minr3_reg;
        out_next.dsq   = out_next.hit ? dsq_next[SQ_IN_W-1:0] : '0;
    end

    // advance payload
    always_ff @(posedge aclk) begin
        if (en) begin
            cax_reg   <= cax_next;
            cay_reg   <= cay_next;
            cbx_reg   <= cbx_next;
            cby_reg   <= cby_next;
            ra1_reg   <= in_data[P_RA +: RADIUS_WIDTH];
            rb1_reg   <= in_data[P_RB +: RADIUS_WIDTH];
            mx_reg    <= mx_next;
            my_reg    <= my_next;
            sx2_reg   <= tx_next[T_W-1];
            sy2_reg   <= ty_next[T_W-1];
            s2_reg    <= SUM_W'(ra1_reg) + SUM_W'(rb1_reg);
            minr2_reg <= (ra1_reg < rb1_reg) ? ra1_reg : rb1_reg;
            sqx_reg   <= mx_reg * mx_reg;
            sqy_reg   <= my_reg * my_reg;
            ss_reg    <= s2_reg * s2_reg;
            ax3_reg   <= mx_reg[SUM_W-1:0];
            ay3_reg   <= my_reg[SUM_W-1:0];
            sx3_reg   <= sx2_reg;
            sy3_reg   <= sy2_reg;
            s3_reg    <= s2_reg;
            minr3_reg <= minr2_reg;
            out_reg   <= out_next;
        end
    end

    // advance valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    assign out_valid = v4_reg;
    assign out_data  = out_reg;

endmodule

[design/cpcm_sqrt.sv]
module cpcm_sqrt (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  cpcm_pkg::front_t  in_data,
    output logic              out_valid,
    output cpcm_pkg::dvin_t   out_data
);
    import cpcm_pkg::*;

    logic [SQ_IN_W-1:0] rad_reg  [ROOT_W];
    logic [REM_W-1:0]   rem_reg  [ROOT_W];
    logic [ROOT_W-1:0]  root_reg [ROOT_W];
    side_t              side_reg [ROOT_W];
    logic [ROOT_W-1:0]  v_reg;

    logic [SQ_IN_W-1:0] rad_in  [ROOT_W];
    logic [REM_W-1:0]   rem_in  [ROOT_W];
    logic [ROOT_W-1:0]  root_in [ROOT_W];
    side_t              side_in [ROOT_W];
    sq_t                step    [ROOT_W];

    side_t              fs;
    logic [REM_W-1:0]   frem;
    logic [ROOT_W-1:0]  froot;
    logic [SUM_W-1:0]   d_next;
    dvin_t              out_reg, out_next;
    logic               out_v_reg;

    // feed each digit stage from the one before it
    always_comb begin
        for (int k = 0; k < ROOT_W; k++) begin
            if (k == 0) begin
                rad_in[k]       = in_data.dsq;
                rem_in[k]       = '0;
                root_in[k]      = '0;
                side_in[k].hit  = in_data.hit;
                side_in[k].zero = in_data.zero;
                side_in[k].sx   = in_data.sx;
                side_in[k].sy   = in_data.sy;
                side_in[k].ax   = in_data.ax;
                side_in[k].ay   = in_data.ay;
                side_in[k].s    = in_data.s;
                side_in[k].minr = in_data.minr;
            end else begin
                rad_in[k]  = rad_reg[k-1];
                rem_in[k]  = rem_reg[k-1];
                root_in[k] = root_reg[k-1];
                side_in[k] = side_reg[k-1];
            end
            step[k] = sqrt_step(rem_in[k], root_in[k], rad_in[k][SQ_IN_W-1 -: 2]);
        end
    end

    // round to nearest and form penetration
    always_comb begin
        fs     = side_reg[ROOT_W-1];
        frem   = rem_reg[ROOT_W-1];
        froot  = root_reg[ROOT_W-1];
        d_next = (frem > REM_W'(froot)) ? (froot + ROOT_W'(1)) : froot;
        out_next.hit  = fs.hit;
        out_next.zero = fs.zero;
        out_next.sx   = fs.sx;
        out_next.sy   = fs.sy;
        out_next.ax   = fs.ax;
        out_next.ay   = fs.ay;
        out_next.d    = d_next;
        if (!fs.hit) begin
            out_next.pen = '0;
        end else if (fs.zero) begin
            out_next.pen = PEN_W'(fs.minr);
        end else begin
            out_next.pen = PEN_W'(fs.s - d_next);
        end
    end

    // advance payload
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < ROOT_W; k++) begin
                rad_reg[k]  <= {rad_in[k][SQ_IN_W-3:0], 2'b00};
                rem_reg[k]  <= step[k].rem;
                root_reg[k] <= step[k].root;
                side_reg[k] <= side_in[k];
            end
            out_reg <= out_next;
        end
    end

    // advance valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg     <= '0;
            out_v_reg <= 1'b0;
        end else if (en) begin
            v_reg     <= {v_reg[ROOT_W-2:0], in_valid};
            out_v_reg <= v_reg[ROOT_W-1];
        end
    end

    assign out_valid = out_v_reg;
    assign out_data  = out_reg;

endmodule

[design/cpcm_div.sv]
module cpcm_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  cpcm_pkg::dvin_t   in_data,
    output logic              out_valid,
    output cpcm_pkg::res_t    out_data
);
    import cpcm_pkg::*;

    localparam logic [Q_W-1:0] ONE = Q_W'(1) << NORMAL_FRAC_BITS;

    // index 0 holds the prepared numerator, 1..Q_W the quotient digits
    logic [SUM_W-1:0] rx_reg [Q_W+1];
    logic [SUM_W-1:0] ry_reg [Q_W+1];
    logic [Q_W-1:0]   lx_reg [Q_W+1];
    logic [Q_W-1:0]   ly_reg [Q_W+1];
    logic [Q_W-1:0]   qx_reg [Q_W+1];
    logic [Q_W-1:0]   qy_reg [Q_W+1];
    logic [SUM_W-1:0] d_reg  [Q_W+1];
    dvside_t          side_reg [Q_W+1];
    logic [Q_W:0]     v_reg;

    logic [NUM_W-1:0] nx_num, ny_num;
    dv_t              stx [Q_W+1];
    dv_t              sty [Q_W+1];

    logic [Q_W-1:0]   satx, saty, sgx, sgy;
    dvside_t          fs;
    res_t             out_reg, out_next;
    logic             out_v_reg;

    // numerators with half the divisor added for rounding
    assign nx_num = (NUM_W'(in_data.ax) << NORMAL_FRAC_BITS) + NUM_W'(in_data.d >> 1);
    assign ny_num = (NUM_W'(in_data.ay) << NORMAL_FRAC_BITS) + NUM_W'(in_data.d >> 1);

    // one quotient bit per stage on each lane
    always_comb begin
        stx[0] = '0;
        sty[0] = '0;
        for (int k = 1; k <= Q_W; k++) begin
            stx[k] = div_step(rx_reg[k-1], d_reg[k-1], lx_reg[k-1][Q_W-1]);
            sty[k] = div_step(ry_reg[k-1], d_reg[k-1], ly_reg[k-1][Q_W-1]);
        end
    end

    // saturate, restore sign and pick the special cases
    always_comb begin
        fs   = side_reg[Q_W];
        satx = (qx_reg[Q_W] > ONE) ? ONE : qx_reg[Q_W];
        saty = (qy_reg[Q_W] > ONE) ? ONE : qy_reg[Q_W];
        sgx  = fs.sx ? (~satx + Q_W'(1)) : satx;
        sgy  = fs.sy ? (~saty + Q_W'(1)) : saty;
        out_next.hit = fs.hit;
        out_next.pen = fs.pen;
        if (!fs.hit) begin
            out_next.nx = '0;
            out_next.ny = '0;
        end else if (fs.zero) begin
            out_next.nx = NORM_W'(ONE);
            out_next.ny = '0;
        end else begin
            out_next.nx = NORM_W'(sgx);
            out_next.ny = NORM_W'(sgy);
        end
    end

    // advance payload
    always_ff @(posedge aclk) begin
        if (en) begin
            rx_reg[0]        <= SUM_W'(nx_num[NUM_W-1:Q_W]);
            ry_reg[0]        <= SUM_W'(ny_num[NUM_W-1:Q_W]);
            lx_reg[0]        <= nx_num[Q_W-1:0];
            ly_reg[0]        <= ny_num[Q_W-1:0];
            qx_reg[0]        <= '0;
            qy_reg[0]        <= '0;
            d_reg[0]         <= in_data.d;
            side_reg[0].hit  <= in_data.hit;
            side_reg[0].zero <= in_data.zero;
            side_reg[0].sx   <= in_data.sx;
            side_reg[0].sy   <= in_data.sy;
            side_reg[0].pen  <= in_data.pen;
            for (int k = 1; k <= Q_W; k++) begin
                rx_reg[k]   <= stx[k].r;
                ry_reg[k]   <= sty[k].r;
                lx_reg[k]   <= {lx_reg[k-1][Q_W-2:0], 1'b0};
                ly_reg[k]   <= {ly_reg[k-1][Q_W-2:0], 1'b0};
                qx_reg[k]   <= {qx_reg[k-1][Q_W-2:0], stx[k].q};
                qy_reg[k]   <= {qy_reg[k-1][Q_W-2:0], sty[k].q};
                d_reg[k]    <= d_reg[k-1];
                side_reg[k] <= side_reg[k-1];
            end
            out_reg <= out_next;
        end
    end

    // advance valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg     <= '0;
            out_v_reg <= 1'b0;
        end else if (en) begin
            v_reg     <= {v_reg[Q_W-1:0], in_valid};
            out_v_reg <= v_reg[Q_W];
        end
    end

    assign out_valid = out_v_reg;
    assign out_data  = out_reg;

endmodule

[design/circle_pair_collision_manifold.sv]
// Pipeline: 4 front stages, 23 root digits, one rounding stage, one numerator stage,
// 16 quotient digits and one output stage lie between request accept and result.
// Throughput: one request per cycle; the whole pipeline freezes while the output
// register holds a result that m_tready has not taken.
// Reset: synchronous active-low aresetn clears all valid bits; payload is not reset.
module circle_pair_collision_manifold (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // pos_a_x, pos_a_y, offset_a_x, offset_a_y, radius_a,
    // pos_b_x, pos_b_y, offset_b_x, offset_b_y, radius_b, zero fill
    input  logic [cpcm_pkg::IN_W-1:0]  s_tdata,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // penetration, normal_x, normal_y, zero fill
    output logic [cpcm_pkg::OUT_W-1:0] m_tdata,
    // hit
    output logic                       m_tuser
);
    import cpcm_pkg::*;

    logic    en;
    logic    f_valid, q_valid;
    front_t  f_data;
    dvin_t   q_data;
    res_t    r_data;

    // advance whenever the output register is free or being drained
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    cpcm_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .in_data   (s_tdata),
        .out_valid (f_valid),
        .out_data  (f_data)
    );

    cpcm_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (f_valid),
        .in_data   (f_data),
        .out_valid (q_valid),
        .out_data  (q_data)
    );

    cpcm_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (q_valid),
        .in_data   (q_data),
        .out_valid (m_tvalid),
        .out_data  (r_data)
    );

    // pack result fields
    always_comb begin
        m_tdata                   = '0;
        m_tdata[P_PEN +: PEN_W]   = r_data.pen;
        m_tdata[P_NX +: NORM_W]   = r_data.nx;
        m_tdata[P_NY +: NORM_W]   = r_data.ny;
        m_tuser                   = r_data.hit;
    end

endmodule

[design/cpcm_checker.sv]
`include "assert_macros.svh"

module cpcm_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_tvalid,
    input logic                       s_tready,
    input logic [cpcm_pkg::IN_W-1:0]  s_tdata,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [cpcm_pkg::OUT_W-1:0] m_tdata,
    input logic                       m_tuser
);
    import cpcm_pkg::*;

    localparam logic signed [NORM_W-1:0] NMAX = NORM_W'(1 << NORMAL_FRAC_BITS);
    localparam logic signed [NORM_W-1:0] NMIN = -NMAX;

    logic signed [NORM_W-1:0] nx, ny;
    logic                     norm_ok;

    assign nx      = m_tdata[P_NX +: NORM_W];
    assign ny      = m_tdata[P_NY +: NORM_W];
    assign norm_ok = (nx <= NMAX) && (nx >= NMIN) && (ny <= NMAX) && (ny >= NMIN);

    // a stalled result holds
    `CPCM_ASSERT_NXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    // no contact reports an all-zero result
    `CPCM_ASSERT_IMP(a_miss_zero, aclk, aresetn, m_tvalid && !m_tuser, m_tdata == '0)
    // normal components stay within plus or minus one
    `CPCM_ASSERT_IMP(a_norm_rng, aclk, aresetn, m_tvalid && m_tuser, norm_ok)
    // input is taken whenever the output side drains
    `CPCM_ASSERT_IMP(a_ready, aclk, aresetn, s_tvalid && m_tready, s_tready)
    // nothing leaves right after reset
    `CPCM_ASSERT_NXT_ALWAYS(a_rst, aclk, !aresetn, !m_tvalid)

endmodule

bind circle_pair_collision_manifold cpcm_checker u_cpcm_checker (.*);

[bench/circle_pair_collision_manifold_tb.sv]
module circle_pair_collision_manifold_tb;
    import cpcm_pkg::*;

    typedef struct {
        logic signed [COORD_WIDTH-1:0] pax, pay, oax, oay;
        logic        [RADIUS_WIDTH-1:0] ra;
        logic signed [COORD_WIDTH-1:0] pbx, pby, obx, oby;
        logic        [RADIUS_WIDTH-1:0] rb;
    } circle_pair_t;

    typedef struct {
        logic              hit;
        logic [PEN_W-1:0]  pen;
        logic [NORM_W-1:0] nx;
        logic [NORM_W-1:0] ny;
    } manifold_t;

    localparam int CYCLE_LIMIT = 400000;

    logic              aclk;
    logic              aresetn;
    logic              s_tvalid;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata;
    logic              m_tvalid;
    logic              m_tready;
    logic [OUT_W-1:0]  m_tdata;
    logic              m_tuser;

    manifold_t expected_manifolds[$];
    int        mismatch_count;
    int        cycle_count;
    int        ready_pct;
    int        burst_left;

    circle_pair_collision_manifold uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    // floor square root, then round to nearest
    function automatic longint unsigned root_nearest(longint unsigned dsq);
        longint unsigned r;
        longint unsigned c;
        r = 0;
        for (int b = 31; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if (c * c <= dsq) r = c;
        end
        if (dsq > r * r + r) r++;
        return r;
    endfunction

    // one normal component, rounded half away from zero and clamped to one
    function automatic logic [NORM_W-1:0] normal_component(longint t, longint unsigned d);
        longint unsigned q;
        longint unsigned one;
        longint unsigned m;
        one = 64'd1 << NORMAL_FRAC_BITS;
        m   = (t < 0) ? longint'(-t) : longint'(t);
        q   = ((m << NORMAL_FRAC_BITS) + (d >> 1)) / d;
        if (q > one) q = one;
        return (t < 0) ? NORM_W'(-longint'(q)) : NORM_W'(q);
    endfunction

    function automatic manifold_t predict_manifold(circle_pair_t p);
        longint cax, cay, cbx, cby, tx, ty;
        longint unsigned dsq, s, d;
        manifold_t m;
        cax = longint'(p.pax) + longint'(p.oax) + longint'({1'b0, p.ra});
        cay = longint'(p.pay) + longint'(p.oay) + longint'({1'b0, p.ra});
        cbx = longint'(p.pbx) + longint'(p.obx) + longint'({1'b0, p.rb});
        cby = longint'(p.pby) + longint'(p.oby) + longint'({1'b0, p.rb});
        tx  = cbx - cax;
        ty  = cby - cay;
        dsq = tx * tx + ty * ty;
        s   = longint'({1'b0, p.ra}) + longint'({1'b0, p.rb});
        m   = '{1'b0, '0, '0, '0};
        if (dsq <= s * s) begin
            m.hit = 1'b1;
            if (dsq == 0) begin
                m.pen = (p.ra < p.rb) ? PEN_W'(p.ra) : PEN_W'(p.rb);
                m.nx  = NORM_W'(1 << NORMAL_FRAC_BITS);
            end else begin
                d    = root_nearest(dsq);
                m.pen = PEN_W'(s - d);
                m.nx = normal_component(tx, d);
                m.ny = normal_component(ty, d);
            end
        end
        return m;
    endfunction

    // drive one request and wait for it to be taken; gaps fall between bursts
    task automatic send_pair(circle_pair_t p);
        if (burst_left == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(0, 4)) @(negedge aclk);
            burst_left = $urandom_range(1, 12);
        end
        s_tdata  = {4'b0, p.rb, p.oby, p.obx, p.pby, p.pbx, p.ra, p.oay, p.oax, p.pay, p.pax};
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        expected_manifolds.push_back(predict_manifold(p));
        burst_left--;
        @(negedge aclk);
        if (burst_left == 0) s_tvalid = 1'b0;
    endtask

    function automatic circle_pair_t pair_of(int pax, int pay, int ra, int pbx, int pby, int rb);
        circle_pair_t p;
        p = '{COORD_WIDTH'(pax), COORD_WIDTH'(pay), '0, '0, RADIUS_WIDTH'(ra),
              COORD_WIDTH'(pbx), COORD_WIDTH'(pby), '0, '0, RADIUS_WIDTH'(rb)};
        return p;
    endfunction

    function automatic circle_pair_t random_pair();
        circle_pair_t p;
        p = '{COORD_WIDTH'($urandom), COORD_WIDTH'($urandom), COORD_WIDTH'($urandom),
              COORD_WIDTH'($urandom), RADIUS_WIDTH'($urandom),
              COORD_WIDTH'($urandom), COORD_WIDTH'($urandom), COORD_WIDTH'($urandom),
              COORD_WIDTH'($urandom), RADIUS_WIDTH'($urandom)};
        return p;
    endfunction

    // place B so its center sits a random step away from A's center
    function automatic circle_pair_t near_pair(int span);
        circle_pair_t p;
        int cax, cay, tx, ty;
        p.pax = COORD_WIDTH'($urandom_range(0, 2 * span) - span);
        p.pay = COORD_WIDTH'($urandom_range(0, 2 * span) - span);
        p.oax = COORD_WIDTH'($urandom_range(0, 2 * span) - span);
        p.oay = COORD_WIDTH'($urandom_range(0, 2 * span) - span);
        p.obx = COORD_WIDTH'($urandom_range(0, 2 * span) - span);
        p.oby = COORD_WIDTH'($urandom_range(0, 2 * span) - span);
        p.ra  = RADIUS_WIDTH'($urandom_range(0, span));
        p.rb  = RADIUS_WIDTH'($urandom_range(0, span));
        cax = int'(p.pax) + int'(p.oax) + int'(p.ra);
        cay = int'(p.pay) + int'(p.oay) + int'(p.ra);
        tx  = $urandom_range(0, 2 * (p.ra + p.rb) + 2) - (p.ra + p.rb) - 1;
        ty  = $urandom_range(0, 2 * (p.ra + p.rb) + 2) - (p.ra + p.rb) - 1;
        if ($urandom_range(0, 7) == 0) ty = 0;
        p.pbx = COORD_WIDTH'(cax + tx - int'(p.rb) - int'(p.obx));
        p.pby = COORD_WIDTH'(cay + ty - int'(p.rb) - int'(p.oby));
        return p;
    endfunction

    task automatic test_coincident();
        ready_pct = 100;
        send_pair(pair_of(0, 0, 0, 0, 0, 0));
        send_pair(pair_of(0, 0, 300, 100, 100, 200));
        send_pair(pair_of(5000, -7000, 4194303, 5000, -7000, 4194303));
        send_pair(pair_of(0, 0, 0, 0, 0, 4194303));
    endtask

    task automatic test_touching();
        ready_pct = 70;
        send_pair(pair_of(0, 0, 256, 512, 0, 256));
        send_pair(pair_of(0, 0, 256, 513, 0, 256));
        send_pair(pair_of(512, 0, 256, 0, 0, 256));
        send_pair(pair_of(0, 0, 1000, 3000, 4000, 4000));
        send_pair(pair_of(0, 0, 1000, 3000, 4001, 4000));
        send_pair(pair_of(0, 0, 1000, 0, -5000, 4000));
        send_pair(pair_of(0, 0, 3, 2, 1, 1));
        send_pair(pair_of(0, 0, 1, 1, 0, 0));
    endtask

    task automatic test_field_extremes();
        circle_pair_t p;
        ready_pct = 50;
        p = '{24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 22'h3FFFFF,
              24'h800000, 24'h800000, 24'h800000, 24'h800000, 22'h3FFFFF};
        send_pair(p);
        p = '{24'h800000, 24'h800000, 24'h800000, 24'h800000, 22'h3FFFFF,
              24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 22'h3FFFFF};
        send_pair(p);
        p = '{24'h800000, 24'h7FFFFF, 24'h000000, 24'h800000, 22'h000000,
              24'h800000, 24'h7FFFFF, 24'h000000, 24'h800000, 22'h3FFFFF};
        send_pair(p);
        send_pair(pair_of(-8388608, 0, 4194303, -8388608 + 1000, 3000, 4194303));
        send_pair(pair_of(8388607, 8388607, 4194303, 8388607 - 7, 8388607 - 5, 4194303));
        send_pair(pair_of(0, 0, 0, 1, 1, 0));
    endtask

    task automatic test_random_contacts(int count);
        for (int i = 0; i < count; i++) begin
            if (i % 100 == 0) ready_pct = (i % 300 == 0) ? 100 : $urandom_range(20, 90);
            case ($urandom_range(0, 9))
                0, 1:    send_pair(random_pair());
                2:       send_pair(near_pair(16));
                3, 4:    send_pair(near_pair(2000));
                default: send_pair(near_pair(1 << 21));
            endcase
        end
    endtask

    // receiver stalls on its own random pattern
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) < ready_pct);
    end

    // compare each accepted result with the oldest expectation
    always @(posedge aclk) begin
        manifold_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_manifolds.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: hit=%0d data=%h", m_tuser, m_tdata);
            end else begin
                want = expected_manifolds.pop_front();
                if (m_tuser !== want.hit || m_tdata[P_NX-1:P_PEN] !== want.pen ||
                    m_tdata[P_NY-1:P_NX] !== want.nx ||
                    m_tdata[OUT_BITS-1:P_NY] !== want.ny) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: exp hit=%0d pen=%h nx=%h ny=%h, got hit=%0d pen=%h nx=%h ny=%h",
                                 want.hit, want.pen, want.nx, want.ny, m_tuser,
                                 m_tdata[P_NX-1:P_PEN], m_tdata[P_NY-1:P_NX],
                                 m_tdata[OUT_BITS-1:P_NY]);
                end
            end
        end
    end

    // end the run if it hangs
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        m_tready       = 1'b0;
        ready_pct      = 100;
        burst_left     = 0;
        mismatch_count = 0;
        cycle_count    = 0;
        repeat (8) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_coincident();
        test_touching();
        test_field_extremes();
        test_random_contacts(800);
        s_tvalid = 1'b0;

        wait (expected_manifolds.size() == 0);
        repeat (60) @(posedge aclk);
        if (mismatch_count == 0 && expected_manifolds.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

[filelist.f]
+incdir+design
design/cpcm_pkg.sv
design/cpcm_front.sv
design/cpcm_sqrt.sv
design/cpcm_div.sv
design/circle_pair_collision_manifold.sv
design/cpcm_checker.sv
bench/circle_pair_collision_manifold_tb.sv
